>>> rtl/core/grpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grpt_pkg
// Shared types and constants for the greedy radius point thinning block.
// ----------------------------------------------------------------------------
package grpt_pkg;

  localparam int MAX_KEPT_DEF    = 256;
  localparam int COORD_WIDTH_DEF = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int RADIUS_W    = 12;
  localparam int R2_W        = 2 * RADIUS_W;
  localparam int TOTAL_W     = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_THIN_ENABLE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ENABLE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THIN_RADIUS   = 2'd2;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd25;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // status from the distance pipe back to the sequencer
  typedef struct packed {
    logic busy;
    logic hit_valid;
    logic hit;
  } dist_status_t;

endpackage : grpt_pkg
`default_nettype wire

>>> rtl/core/grpt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grpt_if
// Valid/ready channels for point beats in and result beats out.
// ----------------------------------------------------------------------------
interface grpt_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic                          station_match;
  logic                          first_of_set;

  modport source (output valid, pos_x, pos_y, station_match, first_of_set, input ready);
  modport sink   (input valid, pos_x, pos_y, station_match, first_of_set, output ready);
endinterface : grpt_in_if

interface grpt_out_if;
  logic       valid;
  logic       ready;
  logic       keep;
  logic [8:0] kept_total;
  logic       table_full;

  modport source (output valid, keep, kept_total, table_full, input ready);
  modport sink   (input valid, keep, kept_total, table_full, output ready);
endinterface : grpt_out_if
`default_nettype wire

>>> rtl/core/grpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grpt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module grpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : grpt_ram
`default_nettype wire

>>> rtl/core/grpt_dist.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grpt_dist
// Three-stage squared distance pipe: abs difference, squares, sum compare.
// ----------------------------------------------------------------------------
module grpt_dist
  import grpt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic signed [COORD_WIDTH-1:0] kx,
  input  wire logic signed [COORD_WIDTH-1:0] ky,
  input  wire logic signed [COORD_WIDTH-1:0] px,
  input  wire logic signed [COORD_WIDTH-1:0] py,
  input  wire logic        [R2_W-1:0]        r2,
  output dist_status_t                       st
);

  localparam int W     = COORD_WIDTH;
  localparam int SQ_W  = 2 * W + 2;
  localparam int CMP_W = (2 * W + 3 > R2_W) ? 2 * W + 3 : R2_W;

  logic signed [W:0] dx, dy;
  logic        [W:0] ax, ay;
  logic        [SQ_W-1:0] sq_x, sq_y;
  logic        [CMP_W-1:0] sum;
  logic s1_v, s2_v, s3_v, hit;

  assign dx = {kx[W-1], kx} - {px[W-1], px};
  assign dy = {ky[W-1], ky} - {py[W-1], py};
  assign sum = CMP_W'(sq_x) + CMP_W'(sq_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
    ax   <= dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
    ay   <= dy[W] ? (W+1)'(-dy) : (W+1)'(dy);
    sq_x <= ax * ax;
    sq_y <= ay * ay;
    hit  <= sum < CMP_W'(r2);
  end

  assign st.busy      = s1_v | s2_v;
  assign st.hit_valid = s3_v;
  assign st.hit       = hit;

endmodule : grpt_dist
`default_nettype wire

>>> rtl/core/greedy_radius_point_thinning.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a point needing no scan goes from IDLE to FINISH, which loads
//   the result register; else SCAN issues one table read per cycle,
//   DRAIN waits out the distance pipe, then FINISH. The next point is
//   accepted only after FINISH, and scanned while the last result still waits.
// Reset: synchronous, clears the kept count and sequencer, resets the config;
//   the coordinate store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// greedy_radius_point_thinning
// Keeps a table of accepted points and, with thinning on, rejects any point
// closer than the radius to one already kept. Coordinates sit in one RAM.
// ----------------------------------------------------------------------------
module greedy_radius_point_thinning
  import grpt_pkg::*;
#(
  parameter int MAX_KEPT    = MAX_KEPT_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  grpt_in_if.sink                     pt_in,
  grpt_out_if.source                  res_out,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int W     = COORD_WIDTH;
  localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W = $clog2(MAX_KEPT + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEPT);

  state_t state, state_next;

  logic                thin_enable, filter_enable;
  logic [RADIUS_W-1:0] thin_radius;

  logic [CNT_W-1:0]    cnt, scan_idx;
  logic signed [W-1:0] px, py;
  logic                offered, hit, rd_v;
  logic [R2_W-1:0]     r2;

  logic                out_valid, out_keep, out_full;
  logic [TOTAL_W-1:0]  out_total;

  logic                accept, issue, finish, pass, do_write;
  logic [CNT_W-1:0]    cnt_eff;
  logic                offer_now;
  logic [2*W-1:0]      rd_data;
  dist_status_t        dist_st;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thin_enable   <= 1'b0;
      filter_enable <= 1'b0;
      thin_radius   <= RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THIN_ENABLE:   thin_enable   <= cfg_data[0];
        REG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        REG_THIN_RADIUS:   thin_radius   <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  assign pt_in.ready = (state == ST_IDLE);
  assign accept      = pt_in.valid && pt_in.ready;
  assign cnt_eff     = pt_in.first_of_set ? '0 : cnt;
  assign offer_now   = !filter_enable || pt_in.station_match;
  assign pass        = offered && !hit;
  assign do_write    = finish && pass && (cnt != CNT_MAX);

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (offer_now && thin_enable && (cnt_eff != '0)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        if (scan_idx + CNT_W'(1) == cnt) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last compare lands in hit on the edge that leaves this state
        if (!rd_v && !dist_st.busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || res_out.ready) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
      hit       <= 1'b0;
      offered   <= 1'b0;
      scan_idx  <= '0;
    end else begin
      rd_v <= issue;
      if (accept) begin
        cnt      <= cnt_eff;
        offered  <= offer_now;
        hit      <= 1'b0;
        scan_idx <= '0;
      end else begin
        if (issue) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        if (dist_st.hit_valid && dist_st.hit) begin
          hit <= 1'b1;
        end
      end
      if (do_write) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px <= pt_in.pos_x;
      py <= pt_in.pos_y;
      r2 <= thin_radius * thin_radius;
    end
    if (finish) begin
      out_keep  <= do_write;
      out_full  <= pass && (cnt == CNT_MAX);
      out_total <= TOTAL_W'(do_write ? cnt + CNT_W'(1) : cnt);
    end
  end

  grpt_ram #(
    .WIDTH (2 * W),
    .DEPTH (MAX_KEPT)
  ) u_store (
    .clk   (clk),
    .we    (do_write),
    .waddr (cnt[IDX_W-1:0]),
    .wdata ({px, py}),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (rd_data)
  );

  grpt_dist #(
    .COORD_WIDTH (W)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_v),
    .kx       (rd_data[2*W-1:W]),
    .ky       (rd_data[W-1:0]),
    .px       (px),
    .py       (py),
    .r2       (r2),
    .st       (dist_st)
  );

  assign res_out.valid      = out_valid;
  assign res_out.keep       = out_keep;
  assign res_out.kept_total = out_total;
  assign res_out.table_full = out_full;

endmodule : greedy_radius_point_thinning
`default_nettype wire

>>> rtl/core/grpt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grpt_checker
// Port-level checks on the thinning block, bound to the top level.
// ----------------------------------------------------------------------------
module grpt_checker #(
  parameter int MAX_KEPT = 256
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       keep,
  input wire logic [8:0] kept_total,
  input wire logic       table_full
);

  localparam logic [8:0] MAX_TOTAL = 9'(MAX_KEPT);

  // a result beat held back must not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({keep, kept_total, table_full}))
    else $error("result beat changed while stalled");

  a_keep_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(keep && table_full))
    else $error("keep and table_full both set");

  a_full_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> kept_total == MAX_TOTAL)
    else $error("table_full with table not at capacity");

  a_keep_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && keep |-> kept_total != 9'd0 || MAX_TOTAL == 9'd0)
    else $error("kept point reported with empty table");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat pending after reset");

endmodule : grpt_checker

bind greedy_radius_point_thinning grpt_checker #(
  .MAX_KEPT (MAX_KEPT)
) u_grpt_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (res_out.valid),
  .out_ready  (res_out.ready),
  .keep       (res_out.keep),
  .kept_total (res_out.kept_total),
  .table_full (res_out.table_full)
);
`default_nettype wire

>>> tb/greedy_radius_point_thinning_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_radius_point_thinning_tb
// Self-checking bench for the point thinning block. A scoreboard keeps its
// own table of kept points, predicts keep / kept_total / table_full for each
// accepted point beat and checks result beats in order. A directed part hits
// coordinate extremes, the filter, radius zero and maximum, exact-radius
// distances and the unused register index; randomised phases then run point
// sets under several settings and idling patterns, fill the table to
// overflow, and hold the result side off long enough to back the block up.
// ----------------------------------------------------------------------------
module greedy_radius_point_thinning_tb;
  import grpt_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;  // worst-case scans over ~1400 points, with a factor of five to spare
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] x;
    logic signed [COORD_WIDTH_DEF-1:0] y;
    logic                              match;
    logic                              first;
  } point_t;

  typedef struct packed {
    logic               keep;
    logic [TOTAL_W-1:0] total;
    logic               full;
  } thin_result_t;

  class thinning_scoreboard;
    logic signed [COORD_WIDTH_DEF-1:0] kept_x [MAX_KEPT_DEF];
    logic signed [COORD_WIDTH_DEF-1:0] kept_y [MAX_KEPT_DEF];
    int unsigned       count;
    bit                thin_on;
    bit                filter_on;
    logic [RADIUS_W-1:0] radius;
    thin_result_t      pending [$];
    int errors, points_seen, kept_seen, full_seen;

    function new();
      count     = 0;
      thin_on   = 1'b0;
      filter_on = 1'b0;
      radius    = RADIUS_RESET;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THIN_ENABLE:   thin_on   = data[0];
        REG_FILTER_ENABLE: filter_on = data[0];
        REG_THIN_RADIUS:   radius    = data[RADIUS_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_point(point_t p);
      thin_result_t r;
      bit     near;
      longint dx, dy, r2;
      r    = '0;
      near = 1'b0;
      points_seen++;
      if (p.first) count = 0;
      if (!filter_on || p.match) begin
        if (thin_on) begin
          r2 = longint'(radius) * longint'(radius);
          for (int i = 0; i < count; i++) begin
            dx = longint'(kept_x[i]) - longint'(p.x);
            dy = longint'(kept_y[i]) - longint'(p.y);
            if (dx * dx + dy * dy < r2) near = 1'b1;
          end
        end
        if (!near) begin
          if (count >= MAX_KEPT_DEF) begin
            r.full = 1'b1;
          end else begin
            kept_x[count] = p.x;
            kept_y[count] = p.y;
            count++;
            r.keep = 1'b1;
          end
        end
      end
      r.total = count[TOTAL_W-1:0];
      kept_seen += r.keep;
      full_seen += r.full;
      pending = {pending, r};
    endfunction

    function void report_field(string field, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
    endfunction

    function void check_result(logic keep, logic [TOTAL_W-1:0] total, logic full);
      thin_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected (keep=%0b total=%0d full=%0b)",
                 $time, keep, total, full);
        return;
      end
      want = pending.pop_front();
      if (keep !== want.keep)   report_field("keep", want.keep, keep);
      if (total !== want.total) report_field("kept_total", want.total, total);
      if (full !== want.full)   report_field("table_full", want.full, full);
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  grpt_in_if #(.COORD_WIDTH(COORD_WIDTH_DEF)) pt_in ();
  grpt_out_if                                 res_out ();

  greedy_radius_point_thinning u_top (
    .clk       (clk),
    .rst       (rst),
    .pt_in     (pt_in),
    .res_out   (res_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  thinning_scoreboard sb = new();
  int sender_idle_pct;
  int stall_pct;
  int hold_requests;
  int phases_run;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // point beats and result beats, both sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && pt_in.valid && pt_in.ready)
      sb.note_point({pt_in.pos_x, pt_in.pos_y, pt_in.station_match, pt_in.first_of_set});
  end

  always @(posedge clk) begin
    if (!rst && res_out.valid && res_out.ready)
      sb.check_result(res_out.keep, res_out.kept_total, res_out.table_full);
  end

  // result side: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int hold_left;
    int hold_seen;
    hold_left     = 0;
    hold_seen     = 0;
    res_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_out.ready <= 1'b0;
      end else begin
        res_out.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timed out with %0d results outstanding", $time, sb.pending.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic point_t mk_point(int x, int y, bit m, bit f);
    return {16'(x), 16'(y), m, f};
  endfunction

  function automatic void set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin sender_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 46; stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  stall_pct = 46; end
      default:       begin sender_idle_pct = 36; stall_pct = 36; end
    endcase
  endfunction

  task automatic send_point(point_t p);
    if ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      pt_in.valid <= 1'b0;
      repeat ($urandom_range(2)) @(negedge clk);
    end
    @(negedge clk);
    pt_in.valid         <= 1'b1;
    pt_in.pos_x         <= p.x;
    pt_in.pos_y         <= p.y;
    pt_in.station_match <= p.match;
    pt_in.first_of_set  <= p.first;
    do @(posedge clk); while (!pt_in.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    pt_in.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // upper bits of the one-bit registers carry junk on purpose
  task automatic configure(bit thin, bit filt, logic [RADIUS_W-1:0] radius);
    write_reg(REG_THIN_ENABLE, {11'($urandom), thin});
    write_reg(REG_FILTER_ENABLE, {11'($urandom), filt});
    write_reg(REG_THIN_RADIUS, radius);
  endtask

  // point sets clustered around a centre, so some fall inside the radius;
  // a fifth are scattered anywhere, and set boundaries are occasionally broken
  task automatic run_random_phase(bit thin, bit filt, logic [RADIUS_W-1:0] radius,
                                  idle_mode_t mode, int n, bit with_hold);
    int     sent, set_len, spread, cx, cy;
    point_t p;
    configure(thin, filt, radius);
    set_idling(mode);
    phases_run++;
    sent   = 0;
    spread = 2 * int'(radius) + 4;
    while (sent < n) begin
      set_len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
      cx      = int'($urandom_range(65535)) - 32768;
      cy      = int'($urandom_range(65535)) - 32768;
      for (int k = 0; k < set_len && sent < n; k++) begin
        if ($urandom_range(4) == 0) begin
          p.x = 16'($urandom);
          p.y = 16'($urandom);
        end else begin
          p.x = 16'(cx + int'($urandom_range(2 * spread)) - spread);
          p.y = 16'(cy + int'($urandom_range(2 * spread)) - spread);
        end
        p.match = ($urandom_range(3) != 0);
        p.first = (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(29) == 0);
        if (with_hold && sent == n / 3) hold_requests++;
        send_point(p);
        sent++;
      end
    end
    wait_drained();
  endtask

  // one long set of distinct points, run past the table size
  task automatic run_fill_phase(bit thin, idle_mode_t mode, int n);
    int     base;
    point_t p;
    configure(thin, 1'b0, 12'd1);
    set_idling(mode);
    phases_run++;
    base = int'($urandom_range(65535)) - 32768;
    for (int k = 0; k < n; k++) begin
      p.x     = 16'(base + k);
      p.y     = 16'($urandom);
      p.match = 1'($urandom);
      p.first = (k == 0);
      send_point(p);
    end
    wait_drained();
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    pt_in.valid         = 1'b0;
    pt_in.pos_x         = '0;
    pt_in.pos_y         = '0;
    pt_in.station_match = 1'b0;
    pt_in.first_of_set  = 1'b0;
    hold_requests       = 0;
    phases_run          = 0;
    set_idling(IDLE_NONE);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: thinning off, everything kept; corner coordinates
    send_point(mk_point(-32768, -32768, 1'b0, 1'b1));
    send_point(mk_point(32767, 32767, 1'b1, 1'b0));
    send_point(mk_point(0, 0, 1'b0, 1'b0));
    send_point(mk_point(-32768, 32767, 1'b0, 1'b0));
    wait_drained();

    // thinning and filter on, radius 5: exact-radius keep, near reject, wide spans
    configure(1'b1, 1'b1, 12'd5);
    send_point(mk_point(0, 0, 1'b1, 1'b1));
    send_point(mk_point(3, 4, 1'b1, 1'b0));
    send_point(mk_point(2, 2, 1'b1, 1'b0));
    send_point(mk_point(100, 100, 1'b0, 1'b0));
    send_point(mk_point(-32768, -32768, 1'b1, 1'b0));
    send_point(mk_point(32767, 32767, 1'b1, 1'b0));
    send_point(mk_point(32767, 32766, 1'b1, 1'b0));
    send_point(mk_point(5, 0, 1'b1, 1'b1));
    wait_drained();

    // radius zero keeps even a repeated point
    write_reg(REG_THIN_RADIUS, 12'd0);
    write_reg(REG_FILTER_ENABLE, 12'd0);
    send_point(mk_point(7, 7, 1'b0, 1'b1));
    send_point(mk_point(7, 7, 1'b0, 1'b0));
    wait_drained();

    // largest radius, just inside and just on it
    write_reg(REG_THIN_RADIUS, 12'd4095);
    send_point(mk_point(0, 0, 1'b0, 1'b1));
    send_point(mk_point(4094, 0, 1'b0, 1'b0));
    send_point(mk_point(4095, 0, 1'b0, 1'b0));
    send_point(mk_point(-2896, -2896, 1'b0, 1'b0));
    wait_drained();
    write_reg(REG_SPARE, 12'hFFF);   // must leave the settings alone
    send_point(mk_point(1, 1, 1'b0, 1'b0));
    wait_drained();

    run_random_phase(1'b1, 1'b0, 12'd25, IDLE_NONE, 100, 1'b0);
    run_random_phase(1'b1, 1'b1, 12'd0, IDLE_SENDER, 100, 1'b1);
    run_random_phase(1'b0, 1'b1, 12'd4095, IDLE_RECEIVER, 100, 1'b0);
    run_random_phase(1'b1, 1'b0, 12'd4095, IDLE_BOTH, 100, 1'b0);
    run_fill_phase(1'b0, IDLE_BOTH, 268);
    run_random_phase(1'b1, 1'b1, 12'($urandom_range(1, 200)), IDLE_NONE, 100, 1'b0);
    run_fill_phase(1'b1, IDLE_RECEIVER, 268);
    run_random_phase(1'b0, 1'b0, 12'($urandom), IDLE_SENDER, 100, 1'b1);
    run_random_phase(1'b1, 1'b1, 12'($urandom_range(2, 60)), IDLE_RECEIVER, 100, 1'b0);
    run_random_phase(1'b1, 1'b0, 12'($urandom), IDLE_BOTH, 100, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
    end
    $display("Checked %0d points: %0d kept, %0d refused on a full table.",
             sb.points_seen, sb.kept_seen, sb.full_seen);
    $display("Directed corners plus %0d randomised phases of settings, idling and back-pressure.",
             phases_run);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule : greedy_radius_point_thinning_tb
